[design/fa_pkg.sv]
// Shared types and constants for the page frame allocator.
// Used by the channel interfaces and by frame_allocator_max_age_evict.
package fa_pkg;

  // Frame store geometry.
  localparam int NUM_PAGES = 32;
  localparam int IDX_W     = $clog2(NUM_PAGES);
  localparam int CNT_W     = IDX_W + 1;

  // Field widths of the item payloads and the configuration register.
  localparam int FUNC_W  = 2;
  localparam int OWNER_W = 8;
  localparam int VPN_W   = 20;
  localparam int PAGE_W  = 5;
  localparam int AGE_W   = 16;
  localparam int CFG_W   = 6;

  // Reset value of the managed frame count.
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(32);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Request function codes.
  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC = 2'd0,
    FN_FREE  = 2'd1,
    FN_QUERY = 2'd2,
    FN_AGE   = 2'd3
  } func_t;

endpackage

[design/fa_in_if.sv]
// Request channel of the page frame allocator: valid/ready plus request fields.
// Depends on fa_pkg for the field widths.
interface fa_in_if;
  logic                         valid;
  logic                         ready;
  logic [fa_pkg::FUNC_W-1:0]    func;
  logic [fa_pkg::OWNER_W-1:0]   owner_id;
  logic [fa_pkg::VPN_W-1:0]     vpn;
  logic [fa_pkg::PAGE_W-1:0]    page;
  logic [fa_pkg::AGE_W-1:0]     age_value;

  modport source (output valid, func, owner_id, vpn, page, age_value, input ready);
  modport sink   (input valid, func, owner_id, vpn, page, age_value, output ready);
endinterface

[design/fa_out_if.sv]
// Result channel of the page frame allocator: valid/ready plus result fields.
// Depends on fa_pkg for the field widths.
interface fa_out_if;
  logic                         valid;
  logic                         ready;
  logic [fa_pkg::PAGE_W-1:0]    result_page;
  logic                         evicted;
  logic [fa_pkg::OWNER_W-1:0]   evicted_owner;
  logic [fa_pkg::VPN_W-1:0]     evicted_vpn;
  logic                         is_allocated;

  modport source (output valid, result_page, evicted, evicted_owner, evicted_vpn,
                  is_allocated, input ready);
  modport sink   (input valid, result_page, evicted, evicted_owner, evicted_vpn,
                  is_allocated, output ready);
endinterface

[design/frame_allocator_max_age_evict.sv]
// Page frame allocator with greatest-age replacement, top level.
// Depends on fa_pkg, fa_in_if and fa_out_if.
// Free, query and write age go from idle straight to the finish step, where the result
// is registered once the output slot is free; allocate first scans the n managed frames,
// then passes the drain and owner read steps. A new item is taken only while idle, after
// the last result is loaded; the age scan reads one frame per cycle from the age memory.
// Reset (synchronous): all frames free, all ages zero, frame count 32; no clearing pass.
module frame_allocator_max_age_evict (
  input  logic                     clk,
  input  logic                     rst_n,
  fa_in_if.sink                    in_ch,
  fa_out_if.source                 out_ch,
  input  logic                     cfg_we,
  input  logic [fa_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int OV_W = fa_pkg::OWNER_W + fa_pkg::VPN_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_RDOV  = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [fa_pkg::CFG_W-1:0]    cfg_r;
  fa_pkg::cnt_t                n_c;

  // Latched request.
  fa_pkg::func_t               op_r;
  logic [fa_pkg::OWNER_W-1:0]  owner_r;
  logic [fa_pkg::VPN_W-1:0]    vpn_r;
  logic [fa_pkg::PAGE_W-1:0]   page_r;
  logic [fa_pkg::AGE_W-1:0]    age_r;
  logic                        in_range_c;
  fa_pkg::idx_t                page_idx_c;

  // Frame state.
  logic [fa_pkg::NUM_PAGES-1:0] used_r;
  logic [fa_pkg::NUM_PAGES-1:0] age_vld_r;
  logic [fa_pkg::AGE_W-1:0]     age_mem [fa_pkg::NUM_PAGES];
  logic [OV_W-1:0]              ov_mem  [fa_pkg::NUM_PAGES];
  logic [fa_pkg::AGE_W-1:0]     age_q_r;
  logic [OV_W-1:0]              ov_q_r;

  // Scan sequencer and compare unit.
  fa_pkg::cnt_t                idx_r, idx_nxt;
  logic                        p_vld_r;
  fa_pkg::idx_t                p_idx_r;
  logic                        p_used_r;
  logic                        p_avld_r;
  logic [fa_pkg::AGE_W-1:0]    age_c;
  logic                        free_found_r, free_found_nxt;
  fa_pkg::idx_t                free_idx_r, free_idx_nxt;
  fa_pkg::idx_t                best_idx_r, best_idx_nxt;
  logic [fa_pkg::AGE_W-1:0]    best_age_r, best_age_nxt;
  fa_pkg::idx_t                sel_idx_c;

  // Output register.
  logic                        out_valid_r;
  logic [fa_pkg::PAGE_W-1:0]   out_page_r;
  logic                        out_ev_r;
  logic [fa_pkg::OWNER_W-1:0]  out_owner_r;
  logic [fa_pkg::VPN_W-1:0]    out_vpn_r;
  logic                        out_alloc_r;

  logic                        in_take_c;
  logic                        out_load_c;
  logic                        last_c;

  // Managed frame count, clamped to 1 .. NUM_PAGES.
  always_comb begin
    if (cfg_r == '0) begin
      n_c = fa_pkg::cnt_t'(1);
    end else if (32'(cfg_r) > 32'(fa_pkg::NUM_PAGES)) begin
      n_c = fa_pkg::cnt_t'(fa_pkg::NUM_PAGES);
    end else begin
      n_c = fa_pkg::cnt_t'(cfg_r);
    end
  end

  assign in_range_c = 32'(page_r) < 32'(n_c);
  assign page_idx_c = fa_pkg::idx_t'(page_r);
  assign in_take_c  = in_ch.valid && in_ch.ready;
  assign out_load_c = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);
  assign last_c     = (idx_r + fa_pkg::cnt_t'(1)) == n_c;
  assign sel_idx_c  = free_found_r ? free_idx_r : best_idx_r;
  assign in_ch.ready = (state_r == ST_IDLE);

  // Sequencer: scan one frame per cycle for allocate, then read and rebind.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (in_take_c) begin
          state_nxt = (fa_pkg::func_t'(in_ch.func) == fa_pkg::FN_ALLOC) ? ST_SCAN : ST_FIN;
        end
      end
      ST_SCAN: begin
        idx_nxt = idx_r + fa_pkg::cnt_t'(1);
        if (last_c) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_RDOV;
      ST_RDOV:  state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_load_c) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Compare unit: first free frame and greatest age, lowest index on ties.
  assign age_c = p_avld_r ? age_q_r : '0;

  always_comb begin
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    best_idx_nxt   = best_idx_r;
    best_age_nxt   = best_age_r;
    if (in_take_c) begin
      free_found_nxt = 1'b0;
    end else if (p_vld_r) begin
      if (!p_used_r && !free_found_r) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = p_idx_r;
      end
      if (p_idx_r == '0 || age_c > best_age_r) begin
        best_idx_nxt = p_idx_r;
        best_age_nxt = age_c;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cfg_r        <= fa_pkg::CFG_RESET;
      idx_r        <= '0;
      p_vld_r      <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      p_vld_r      <= (state_r == ST_SCAN);
      free_found_r <= free_found_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (out_load_c) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Used bits and age valid bits; an age that is not valid reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      age_vld_r <= '0;
    end else if (out_load_c) begin
      case (op_r)
        fa_pkg::FN_ALLOC: begin
          used_r[sel_idx_c]    <= 1'b1;
          age_vld_r[sel_idx_c] <= 1'b0;
        end
        fa_pkg::FN_FREE: begin
          if (in_range_c) begin
            used_r[page_idx_c] <= 1'b0;
          end
        end
        fa_pkg::FN_AGE: begin
          if (in_range_c) begin
            age_vld_r[page_idx_c] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Age memory: written on write age, read one frame a cycle during the scan.
  always_ff @(posedge clk) begin
    if (out_load_c && op_r == fa_pkg::FN_AGE && in_range_c) begin
      age_mem[page_idx_c] <= age_r;
    end
    if (state_r == ST_SCAN) begin
      age_q_r <= age_mem[idx_r[fa_pkg::IDX_W-1:0]];
    end
  end

  // Owner and vpn memory: read at the chosen frame, then rebound.
  always_ff @(posedge clk) begin
    if (out_load_c && op_r == fa_pkg::FN_ALLOC) begin
      ov_mem[sel_idx_c] <= {owner_r, vpn_r};
    end
    if (state_r == ST_RDOV) begin
      ov_q_r <= ov_mem[sel_idx_c];
    end
  end

  // Payload registers: request latch, scan stage and compare results.
  always_ff @(posedge clk) begin
    if (in_take_c) begin
      op_r    <= fa_pkg::func_t'(in_ch.func);
      owner_r <= in_ch.owner_id;
      vpn_r   <= in_ch.vpn;
      page_r  <= in_ch.page;
      age_r   <= in_ch.age_value;
    end
    p_idx_r    <= idx_r[fa_pkg::IDX_W-1:0];
    p_used_r   <= used_r[idx_r[fa_pkg::IDX_W-1:0]];
    p_avld_r   <= age_vld_r[idx_r[fa_pkg::IDX_W-1:0]];
    free_idx_r <= free_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_age_r <= best_age_nxt;
  end

  // Result item.
  always_ff @(posedge clk) begin
    if (out_load_c) begin
      out_page_r  <= '0;
      out_ev_r    <= 1'b0;
      out_owner_r <= '0;
      out_vpn_r   <= '0;
      out_alloc_r <= 1'b0;
      case (op_r)
        fa_pkg::FN_ALLOC: begin
          out_page_r <= fa_pkg::PAGE_W'(sel_idx_c);
          if (!free_found_r) begin
            out_ev_r    <= 1'b1;
            out_owner_r <= ov_q_r[OV_W-1:fa_pkg::VPN_W];
            out_vpn_r   <= ov_q_r[fa_pkg::VPN_W-1:0];
          end
        end
        fa_pkg::FN_QUERY: out_alloc_r <= in_range_c && used_r[page_idx_c];
        default: ;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_page   = out_page_r;
  assign out_ch.evicted       = out_ev_r;
  assign out_ch.evicted_owner = out_owner_r;
  assign out_ch.evicted_vpn   = out_vpn_r;
  assign out_ch.is_allocated  = out_alloc_r;

  // Non-allocate items go straight to the finish step.
  a_short_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take_c && fa_pkg::func_t'(in_ch.func) != fa_pkg::FN_ALLOC) |=> state_r == ST_FIN)
    else $error("non-allocate item did not go to the finish step");

  // The scan never addresses a frame outside the managed range.
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> idx_r < n_c)
    else $error("scan index beyond managed frame count");

  // An allocated frame is marked used right after the result is loaded.
  a_alloc_used: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load_c && op_r == fa_pkg::FN_ALLOC) |=> used_r[$past(sel_idx_c)])
    else $error("allocated frame not marked used");

  // An eviction, which happens only when the scan saw no free frame, picks a used frame.
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load_c && op_r == fa_pkg::FN_ALLOC && !free_found_r) |-> used_r[sel_idx_c])
    else $error("eviction chose a free frame");

endmodule
